>>> sv/pdb_pkg.sv
// Shared types and constants for the Porter-Duff pixel blender.
// Holds the blend mode codes, the pixel word layout and the per-pixel control word.
// No dependencies.
package pdb_pkg;

  localparam int unsigned ChanWidth = 8;
  localparam int unsigned ModeWidth = 4;

  typedef logic [ChanWidth-1:0] chan_t;

  typedef enum logic [ModeWidth-1:0] {
    MODE_CLEAR   = 4'd0,
    MODE_SRC     = 4'd1,
    MODE_DST     = 4'd2,
    MODE_SRCOVER = 4'd3,
    MODE_DSTOVER = 4'd4,
    MODE_SRCIN   = 4'd5,
    MODE_DSTIN   = 4'd6,
    MODE_SRCOUT  = 4'd7,
    MODE_DSTOUT  = 4'd8,
    MODE_SRCATOP = 4'd9,
    MODE_DSTATOP = 4'd10,
    MODE_XOR     = 4'd11
  } mode_e;

  localparam chan_t ChanZero = 8'd0;
  localparam chan_t ChanFull = 8'd255;

  typedef struct packed {
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // Per-pixel blend controls: a channel result is
  // pass_src*S + pass_dst*D + div255(fac_src*S) + div255(fac_dst*D).
  typedef struct packed {
    chan_t fac_src;
    chan_t fac_dst;
    logic  pass_src;
    logic  pass_dst;
  } ctrl_t;

endpackage

>>> sv/pdb_decode.sv
// First pipeline stage of the blender: turns the mode and both alphas into the
// per-pixel control word and registers it with the pixels. Depends on pdb_pkg.
module pdb_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [3:0]      mode,
  input  pdb_pkg::pixel_t src_in,
  input  pdb_pkg::pixel_t dst_in,
  output logic            valid,
  output pdb_pkg::ctrl_t  ctrl,
  output pdb_pkg::pixel_t src,
  output pdb_pkg::pixel_t dst
);
  import pdb_pkg::*;

  ctrl_t ctrl_next;
  chan_t sa;
  chan_t da;
  chan_t inv_sa;
  chan_t inv_da;
  logic  sa_zero;
  logic  da_zero;
  logic  sa_full;
  logic  da_full;

  assign sa      = src_in.alpha;
  assign da      = dst_in.alpha;
  assign inv_sa  = ChanFull - sa;
  assign inv_da  = ChanFull - da;
  assign sa_zero = (sa == ChanZero);
  assign da_zero = (da == ChanZero);
  assign sa_full = (sa == ChanFull);
  assign da_full = (da == ChanFull);

  always_comb begin
    ctrl_next = '0;
    unique case (mode)
      MODE_CLEAR: begin
      end
      MODE_SRC: begin
        ctrl_next.pass_src = 1'b1;
      end
      MODE_DST: begin
        ctrl_next.pass_dst = 1'b1;
      end
      MODE_SRCOVER: begin
        ctrl_next.pass_src = 1'b1;
        ctrl_next.fac_dst  = (sa_full || da_zero) ? ChanZero : inv_sa;
      end
      MODE_DSTOVER: begin
        ctrl_next.pass_dst = 1'b1;
        ctrl_next.fac_src  = (da_full || sa_zero) ? ChanZero : inv_da;
      end
      MODE_SRCIN: begin
        ctrl_next.fac_src = (sa_zero || da_zero) ? ChanZero : da;
      end
      MODE_DSTIN: begin
        ctrl_next.fac_dst = (sa_zero || da_zero) ? ChanZero : sa;
      end
      MODE_SRCOUT: begin
        ctrl_next.fac_src = (da_full || sa_zero) ? ChanZero : inv_da;
      end
      MODE_DSTOUT: begin
        ctrl_next.fac_dst = (sa_full || da_zero) ? ChanZero : inv_sa;
      end
      MODE_SRCATOP: begin
        if (!da_zero) begin
          ctrl_next.fac_src = da;
          ctrl_next.fac_dst = inv_sa;
        end
      end
      MODE_DSTATOP: begin
        if (!sa_zero) begin
          ctrl_next.fac_dst = sa;
          ctrl_next.fac_src = inv_da;
        end
      end
      MODE_XOR: begin
        priority if (sa_full || da_zero) begin
          ctrl_next.fac_src = inv_da;
        end else if (da_full || sa_zero) begin
          ctrl_next.fac_dst = inv_sa;
        end else begin
          ctrl_next.fac_src = inv_da;
          ctrl_next.fac_dst = inv_sa;
        end
      end
      default: begin
        // Undefined modes pass the source pixel through.
        ctrl_next.pass_src = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctrl <= ctrl_next;
      src  <= src_in;
      dst  <= dst_in;
    end
  end

endmodule

>>> sv/pdb_lane.sv
// One colour channel of the blender: multiply, divide by 255, then add and saturate,
// each in a register stage of its own. Depends on pdb_pkg.
module pdb_lane (
  input  logic           clk,
  input  pdb_pkg::ctrl_t ctrl,
  input  pdb_pkg::chan_t s,
  input  pdb_pkg::chan_t d,
  output pdb_pkg::chan_t result
);
  import pdb_pkg::*;

  localparam int unsigned ProdWidth = 2 * ChanWidth;
  localparam int unsigned SumWidth  = ChanWidth + 2;

  logic [ProdWidth-1:0] prod_s;
  logic [ProdWidth-1:0] prod_d;
  chan_t                pass_s2;
  chan_t                pass_d2;
  chan_t                quot_s;
  chan_t                quot_d;
  chan_t                pass_s3;
  chan_t                pass_d3;
  chan_t                quot_s_next;
  chan_t                quot_d_next;
  logic [SumWidth-1:0]  sum;

  // Rounded division by 255: ((x+128)*257)>>16 equals (y + (y>>8))>>8 with y = x+128.
  function automatic chan_t div255(input logic [ProdWidth-1:0] x);
    logic [ProdWidth:0] y;
    logic [ProdWidth:0] t;
    y = {1'b0, x} + (ProdWidth+1)'(128);
    t = y + {{ChanWidth{1'b0}}, y[ProdWidth:ChanWidth]};
    return t[ProdWidth-1:ChanWidth];
  endfunction

  assign quot_s_next = div255(prod_s);
  assign quot_d_next = div255(prod_d);
  assign sum = {2'b00, pass_s3} + {2'b00, pass_d3} + {2'b00, quot_s} + {2'b00, quot_d};

  always_ff @(posedge clk) begin
    prod_s  <= {{ChanWidth{1'b0}}, ctrl.fac_src} * {{ChanWidth{1'b0}}, s};
    prod_d  <= {{ChanWidth{1'b0}}, ctrl.fac_dst} * {{ChanWidth{1'b0}}, d};
    pass_s2 <= ctrl.pass_src ? s : ChanZero;
    pass_d2 <= ctrl.pass_dst ? d : ChanZero;
    quot_s  <= quot_s_next;
    quot_d  <= quot_d_next;
    pass_s3 <= pass_s2;
    pass_d3 <= pass_d2;
    result  <= (sum > SumWidth'(ChanFull)) ? ChanFull : sum[ChanWidth-1:0];
  end

endmodule

>>> sv/porter_duff_pixel_blend.sv
// Porter-Duff compositor for premultiplied 8-bit ARGB pixels, four-stage pipeline.
// A word taken at one clock edge passes the decode register and the lane's product,
// quotient and result registers, and is on the result ports, with done high, once
// the result register holds it. Throughput: one pixel every cycle; busy stays low.
// The result is held for one cycle only, as the receiver cannot stall.
// Reset (rst, synchronous) empties the pipeline and sets the blend mode to src-over.
module porter_duff_pixel_blend (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data,
  input  pdb_pkg::chan_t      src_alpha,
  input  pdb_pkg::chan_t      src_red,
  input  pdb_pkg::chan_t      src_green,
  input  pdb_pkg::chan_t      src_blue,
  input  pdb_pkg::chan_t      dst_alpha,
  input  pdb_pkg::chan_t      dst_red,
  input  pdb_pkg::chan_t      dst_green,
  input  pdb_pkg::chan_t      dst_blue,
  output logic                done,
  output pdb_pkg::chan_t      out_alpha,
  output pdb_pkg::chan_t      out_red,
  output pdb_pkg::chan_t      out_green,
  output pdb_pkg::chan_t      out_blue
);
  import pdb_pkg::*;

  // The blend mode register. Each word samples the mode as it enters the pipeline,
  // so a write never disturbs pixels already in flight and can always be taken.
  logic [ModeWidth-1:0] mode;

  pixel_t src_in;
  pixel_t dst_in;
  pixel_t src1;
  pixel_t dst1;
  ctrl_t  ctrl1;
  logic   valid1;
  logic   valid2;
  logic   valid3;
  logic   take;

  // Every stage advances every cycle, so the block never pushes back on its source.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  assign src_in = '{alpha: src_alpha, red: src_red, green: src_green, blue: src_blue};
  assign dst_in = '{alpha: dst_alpha, red: dst_red, green: dst_green, blue: dst_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SRCOVER;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Stage one: the mode and the alpha shortcuts collapse into two product factors
  // and two pass-through enables, shared by all four channels.
  pdb_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .mode   (mode),
    .src_in (src_in),
    .dst_in (dst_in),
    .valid  (valid1),
    .ctrl   (ctrl1),
    .src    (src1),
    .dst    (dst1)
  );

  // Stages two to four run in each channel lane: products, division by 255,
  // then the sum with saturation into the output register.
  pdb_lane u_lane_alpha (
    .clk    (clk),
    .ctrl   (ctrl1),
    .s      (src1.alpha),
    .d      (dst1.alpha),
    .result (out_alpha)
  );

  pdb_lane u_lane_red (
    .clk    (clk),
    .ctrl   (ctrl1),
    .s      (src1.red),
    .d      (dst1.red),
    .result (out_red)
  );

  pdb_lane u_lane_green (
    .clk    (clk),
    .ctrl   (ctrl1),
    .s      (src1.green),
    .d      (dst1.green),
    .result (out_green)
  );

  pdb_lane u_lane_blue (
    .clk    (clk),
    .ctrl   (ctrl1),
    .s      (src1.blue),
    .d      (dst1.blue),
    .result (out_blue)
  );

  // Valid bits follow the data through the lane stages; done marks the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid2 <= valid1;
      valid3 <= valid2;
      done   <= valid3;
    end
  end

endmodule

>>> sv/pdb_checker.sv
// Port-level checks for the Porter-Duff blender, bound to the top level.
// Depends on porter_duff_pixel_blend.
module pdb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("word taken but no result four cycles later");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching word");

  a_reset_clears_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("pipeline pushed back on its source");

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
